// ===== rtl/core/esx_pkg.sv =====
// ----------------------------------------------------------------------------
// esx_pkg: shared types and constants for the XYZ Euler rotation matrix
// Holds the beat structs, the fixed-point formats and the CORDIC arctangent
// table used by the sine/cosine lanes.
// ----------------------------------------------------------------------------
package esx_pkg;

  // Field formats: angles are Q3.(ANGLE_WIDTH-3), entries Q2.(RESULT_WIDTH-2).
  localparam int ANGLE_WIDTH  = 16;
  localparam int RESULT_WIDTH = 16;

  // CORDIC working constants in Q30.
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] PI_Q30     = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;

  // Pipeline depths: prep + iterations + finishing stage, then the merge.
  localparam int LANE_STAGES  = CORDIC_STEPS + 2;
  localparam int MERGE_STAGES = 5;
  localparam int TOTAL_STAGES = LANE_STAGES + MERGE_STAGES;

  localparam logic signed [32:0] ATAN_Q30 [CORDIC_STEPS] = '{
    33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159, 33'sd67021687,
    33'sd33543516,  33'sd16775851,  33'sd8388437,   33'sd4194283,   33'sd2097149,
    33'sd1048576,   33'sd524288,    33'sd262144,    33'sd131072,    33'sd65536,
    33'sd32768,     33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
    33'sd1024,      33'sd512,       33'sd256,       33'sd128,       33'sd64,
    33'sd32,        33'sd16,        33'sd8,         33'sd4,         33'sd2
  };

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] angle_x;
    logic signed [ANGLE_WIDTH-1:0] angle_y;
    logic signed [ANGLE_WIDTH-1:0] angle_z;
  } esx_in_t;

  typedef struct packed {
    logic signed [RESULT_WIDTH-1:0] m00;
    logic signed [RESULT_WIDTH-1:0] m01;
    logic signed [RESULT_WIDTH-1:0] m02;
    logic signed [RESULT_WIDTH-1:0] m10;
    logic signed [RESULT_WIDTH-1:0] m11;
    logic signed [RESULT_WIDTH-1:0] m12;
    logic signed [RESULT_WIDTH-1:0] m20;
    logic signed [RESULT_WIDTH-1:0] m21;
    logic signed [RESULT_WIDTH-1:0] m22;
  } esx_out_t;

  // Per-stage load enables handed from the control to the datapath.
  typedef struct packed {
    logic [LANE_STAGES-1:0]  lane;
    logic [MERGE_STAGES-1:0] merge;
  } esx_en_t;

endpackage

// ===== rtl/core/euler_xyz_rotation_matrix.sv =====
// Throughput: one matrix per cycle while the output is not stalled; the three
// 32-stage CORDIC lanes and the 5-stage product merge are all fully pipelined.
// Empty stages fill in under a stalled output, so input keeps flowing until
// every stage holds a beat.
// Reset clears all stage valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// euler_xyz_rotation_matrix: XYZ Euler angles to a 3x3 rotation matrix
// Three CORDIC lanes give sine and cosine of each angle; the merge forms the
// nine entries. A valid bit per stage with a ready chain controls flow.
// ----------------------------------------------------------------------------
module euler_xyz_rotation_matrix
  import esx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  esx_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output esx_out_t out_data
);

  logic [TOTAL_STAGES-1:0] vld;
  logic [TOTAL_STAGES-1:0] vld_up;
  logic [TOTAL_STAGES:0]   rdy;
  esx_en_t                 en;

  logic signed [31:0] sx, cx, sy, cy, sz, cz;

  // Ready chain: a stage loads when it is empty or its beat moves on.
  always_comb begin
    rdy[TOTAL_STAGES] = !out_stall;
    for (int k = TOTAL_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    en.lane  = rdy[LANE_STAGES-1:0];
    en.merge = rdy[TOTAL_STAGES-1:LANE_STAGES];
  end

  // Valid bit offered to each stage by the stage before it.
  assign vld_up = {vld[TOTAL_STAGES-2:0], in_valid};

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < TOTAL_STAGES; k++) begin
        if (rdy[k]) vld[k] <= vld_up[k];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[TOTAL_STAGES-1];

  esx_cordic u_lane_x (.clk, .en(en.lane), .angle(in_data.angle_x), .sin_q(sx), .cos_q(cx));
  esx_cordic u_lane_y (.clk, .en(en.lane), .angle(in_data.angle_y), .sin_q(sy), .cos_q(cy));
  esx_cordic u_lane_z (.clk, .en(en.lane), .angle(in_data.angle_z), .sin_q(sz), .cos_q(cz));

  esx_merge u_merge (
    .clk,
    .en     (en.merge),
    .sx, .cx, .sy, .cy, .sz, .cz,
    .result (out_data)
  );

endmodule

// ===== rtl/core/esx_cordic.sv =====
// ----------------------------------------------------------------------------
// esx_cordic: one pipelined sine/cosine lane
// Clamps and folds the angle into [-pi/2, pi/2], runs one CORDIC rotation
// per stage and applies the cosine sign fix in a final stage.
// ----------------------------------------------------------------------------
module esx_cordic
  import esx_pkg::*;
(
  input  logic                          clk,
  input  logic [LANE_STAGES-1:0]        en,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output logic signed [31:0]            sin_q,
  output logic signed [31:0]            cos_q
);

  logic signed [33:0] xr [CORDIC_STEPS+1];
  logic signed [33:0] yr [CORDIC_STEPS+1];
  logic signed [32:0] zr [CORDIC_STEPS+1];
  logic               nr [CORDIC_STEPS+1];

  logic signed [33:0] a_wide;
  logic signed [33:0] a_clamp;
  logic signed [33:0] z_fold;
  logic               neg_fold;

  // Scale to Q30, clamp to +/-pi and fold into the right half plane.
  always_comb begin
    a_wide  = 34'(angle) <<< (33 - ANGLE_WIDTH);
    a_clamp = a_wide;
    if (a_wide > PI_Q30) a_clamp = PI_Q30;
    if (a_wide < -PI_Q30) a_clamp = -PI_Q30;
    z_fold   = a_clamp;
    neg_fold = 1'b0;
    if (a_clamp > HALF_PI_Q30) begin
      z_fold   = PI_Q30 - a_clamp;
      neg_fold = 1'b1;
    end else if (a_clamp < -HALF_PI_Q30) begin
      z_fold   = -PI_Q30 - a_clamp;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xr[0] <= GAIN_Q30;
      yr[0] <= '0;
      zr[0] <= 33'(z_fold);
      nr[0] <= neg_fold;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        nr[i+1] <= nr[i];
        if (zr[i] >= 0) begin
          xr[i+1] <= xr[i] - (yr[i] >>> i);
          yr[i+1] <= yr[i] + (xr[i] >>> i);
          zr[i+1] <= zr[i] - ATAN_Q30[i];
        end else begin
          xr[i+1] <= xr[i] + (yr[i] >>> i);
          yr[i+1] <= yr[i] - (xr[i] >>> i);
          zr[i+1] <= zr[i] + ATAN_Q30[i];
        end
      end
    end
  end

  // Final stage: cosine sign from the fold.
  always_ff @(posedge clk) begin
    if (en[LANE_STAGES-1]) begin
      sin_q <= 32'(yr[CORDIC_STEPS]);
      cos_q <= nr[CORDIC_STEPS] ? 32'(-xr[CORDIC_STEPS]) : 32'(xr[CORDIC_STEPS]);
    end
  end

endmodule

// ===== rtl/core/esx_merge.sv =====
// ----------------------------------------------------------------------------
// esx_merge: combines the three lanes into the rotation matrix
// Two rounds of Q30 products with registered rounding, the nine entry sums,
// then rounding and saturation into the result format.
// ----------------------------------------------------------------------------
module esx_merge
  import esx_pkg::*;
(
  input  logic                    clk,
  input  logic [MERGE_STAGES-1:0] en,
  input  logic signed [31:0]      sx,
  input  logic signed [31:0]      cx,
  input  logic signed [31:0]      sy,
  input  logic signed [31:0]      cy,
  input  logic signed [31:0]      sz,
  input  logic signed [31:0]      cz,
  output esx_out_t                result
);

  localparam int SH = 32 - RESULT_WIDTH;
  localparam logic signed [33:0] LIM = 34'sd1 <<< (RESULT_WIDTH - 2);
  localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

  // Product index names for the first round.
  localparam int CYCZ = 0, CYSZ = 1, CXSZ = 2, CZSX = 3, CXCZ = 4;
  localparam int SXSY = 5, SXSZ = 6, CXSY = 7, CYSX = 8, CXCY = 9;

  logic signed [63:0] p1 [10];
  logic signed [31:0] sy1, sz1;
  logic signed [31:0] r2 [10];
  logic signed [31:0] sy2, sz2;
  logic signed [63:0] c3 [4];
  logic signed [31:0] r3 [10];
  logic signed [31:0] sy3;
  logic signed [32:0] e4 [9];

  function automatic logic signed [32:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + HALF_Q30) >>> 30;
    return 33'(t);
  endfunction

  function automatic logic signed [RESULT_WIDTH-1:0] to_res(input logic signed [32:0] v);
    logic signed [33:0] r;
    r = 34'(v);
    if (SH > 0) r = (r + (34'sd1 <<< (SH - 1))) >>> SH;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return RESULT_WIDTH'(r);
  endfunction

  // First products.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1[CYCZ] <= cy * cz;
      p1[CYSZ] <= cy * sz;
      p1[CXSZ] <= cx * sz;
      p1[CZSX] <= cz * sx;
      p1[CXCZ] <= cx * cz;
      p1[SXSY] <= sx * sy;
      p1[SXSZ] <= sx * sz;
      p1[CXSY] <= cx * sy;
      p1[CYSX] <= cy * sx;
      p1[CXCY] <= cx * cy;
      sy1      <= sy;
      sz1      <= sz;
    end
  end

  // Round them back to Q30.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 10; k++) r2[k] <= 32'(rnd30(p1[k]));
      sy2 <= sy1;
      sz2 <= sz1;
    end
  end

  // Second products for the cross terms.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      c3[0] <= r2[CZSX] * sy2;
      c3[1] <= r2[SXSY] * sz2;
      c3[2] <= r2[CXCZ] * sy2;
      c3[3] <= r2[CXSY] * sz2;
      r3    <= r2;
      sy3   <= sy2;
    end
  end

  // Entry sums.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      e4[0] <= 33'(r3[CYCZ]);
      e4[1] <= -33'(r3[CYSZ]);
      e4[2] <= 33'(sy3);
      e4[3] <= 33'(r3[CXSZ]) + rnd30(c3[0]);
      e4[4] <= 33'(r3[CXCZ]) - rnd30(c3[1]);
      e4[5] <= -33'(r3[CYSX]);
      e4[6] <= 33'(r3[SXSZ]) - rnd30(c3[2]);
      e4[7] <= 33'(r3[CZSX]) + rnd30(c3[3]);
      e4[8] <= 33'(r3[CXCY]);
    end
  end

  // Output register: round and saturate.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      result.m00 <= to_res(e4[0]);
      result.m01 <= to_res(e4[1]);
      result.m02 <= to_res(e4[2]);
      result.m10 <= to_res(e4[3]);
      result.m11 <= to_res(e4[4]);
      result.m12 <= to_res(e4[5]);
      result.m20 <= to_res(e4[6]);
      result.m21 <= to_res(e4[7]);
      result.m22 <= to_res(e4[8]);
    end
  end

endmodule

// ===== rtl/core/esx_checker.sv =====
// ----------------------------------------------------------------------------
// esx_checker: port-level checks for the rotation matrix block
// Watches the handshakes and the output range; bound to the top level.
// ----------------------------------------------------------------------------
module esx_checker
  import esx_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input esx_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input esx_out_t out_data
);

  localparam logic signed [RESULT_WIDTH-1:0] LIM = RESULT_WIDTH'(1 <<< (RESULT_WIDTH - 2));

  // A stalled output beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // The input only backs up when the whole pipe is full behind a stall.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // Diagonal entries stay within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.m00 <= LIM && out_data.m00 >= -LIM &&
                  out_data.m11 <= LIM && out_data.m11 >= -LIM &&
                  out_data.m22 <= LIM && out_data.m22 >= -LIM)
    else $error("matrix entry out of range");

endmodule

bind euler_xyz_rotation_matrix esx_checker u_esx_checker (.*);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the XYZ Euler rotation matrix
// Drives angle triples with random gaps and output stalls. The scoreboard
// predicts each matrix with its own CORDIC sine/cosine and Q30 products and
// compares every output beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import esx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  esx_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  esx_out_t out_data;

  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  euler_xyz_rotation_matrix i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // Matrix predictor and the queue of matrices still owed by the block.
  class matrix_scoreboard;
    esx_out_t pending_mats[$];

    static function longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    static function longint qmul(longint a, longint b);
      return floor_shift(a * b + (64'sd1 <<< 29), 30);
    endfunction

    static function void sin_cos(logic [ANGLE_WIDTH-1:0] raw,
                                 output longint s, output longint c);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'($signed(raw)) * (64'sd1 <<< (33 - ANGLE_WIDTH));
      flip = 1'b0;
      x = longint'(GAIN_Q30);
      y = 0;
      if (z > longint'(PI_Q30)) z = longint'(PI_Q30);
      if (z < -longint'(PI_Q30)) z = -longint'(PI_Q30);
      if (z > longint'(HALF_PI_Q30)) begin
        z = longint'(PI_Q30) - z;
        flip = 1'b1;
      end else if (z < -longint'(HALF_PI_Q30)) begin
        z = -longint'(PI_Q30) - z;
        flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = floor_shift(y, i);
        dy = floor_shift(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
        end
      end
      s = y;
      c = flip ? -x : x;
    endfunction

    static function logic [RESULT_WIDTH-1:0] to_entry(longint v);
      int sh;
      longint lim, r;
      sh = 32 - RESULT_WIDTH;
      lim = 64'sd1 <<< (RESULT_WIDTH - 2);
      r = (sh > 0) ? floor_shift(v + (64'sd1 <<< (sh - 1)), sh) : v;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[RESULT_WIDTH-1:0];
    endfunction

    function void note_angles(esx_in_t a);
      longint sx, cx, sy, cy, sz, cz;
      esx_out_t m;
      sin_cos(a.angle_x, sx, cx);
      sin_cos(a.angle_y, sy, cy);
      sin_cos(a.angle_z, sz, cz);
      m.m00 = to_entry(qmul(cy, cz));
      m.m01 = to_entry(-qmul(cy, sz));
      m.m02 = to_entry(sy);
      m.m10 = to_entry(qmul(cx, sz) + qmul(qmul(cz, sx), sy));
      m.m11 = to_entry(qmul(cx, cz) - qmul(qmul(sx, sy), sz));
      m.m12 = to_entry(-qmul(cy, sx));
      m.m20 = to_entry(qmul(sx, sz) - qmul(qmul(cx, cz), sy));
      m.m21 = to_entry(qmul(cz, sx) + qmul(qmul(cx, sy), sz));
      m.m22 = to_entry(qmul(cx, cy));
      pending_mats.push_back(m);
    endfunction

    task check_matrix(esx_out_t got);
      esx_out_t e;
      if (pending_mats.size() == 0) begin
        report_mismatch("output beat with no matrix pending");
        return;
      end
      e = pending_mats.pop_front();
      if (got.m00 !== e.m00) report_mismatch($sformatf("m00 %0d exp %0d", got.m00, e.m00));
      if (got.m01 !== e.m01) report_mismatch($sformatf("m01 %0d exp %0d", got.m01, e.m01));
      if (got.m02 !== e.m02) report_mismatch($sformatf("m02 %0d exp %0d", got.m02, e.m02));
      if (got.m10 !== e.m10) report_mismatch($sformatf("m10 %0d exp %0d", got.m10, e.m10));
      if (got.m11 !== e.m11) report_mismatch($sformatf("m11 %0d exp %0d", got.m11, e.m11));
      if (got.m12 !== e.m12) report_mismatch($sformatf("m12 %0d exp %0d", got.m12, e.m12));
      if (got.m20 !== e.m20) report_mismatch($sformatf("m20 %0d exp %0d", got.m20, e.m20));
      if (got.m21 !== e.m21) report_mismatch($sformatf("m21 %0d exp %0d", got.m21, e.m21));
      if (got.m22 !== e.m22) report_mismatch($sformatf("m22 %0d exp %0d", got.m22, e.m22));
    endtask
  endclass

  matrix_scoreboard sb = new();

  // Watch both handshakes at the rising edge.
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_angles(in_data);
      if (out_valid && !out_stall) sb.check_matrix(out_data);
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output stall changes at the falling edge.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 32);
  end

  // Send one beat, with a random gap before it, and hold it until accepted.
  // Valid drops only inside a gap, so back-to-back beats keep it high.
  task automatic send_angles(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{angle_x: ax, angle_y: ay, angle_z: az};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Angle mostly in +/-pi, sometimes any 16-bit pattern to hit the clamp.
  function automatic logic [15:0] pick_angle();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return ($urandom_range(1)) ? 16'sd25736 : -16'sd25736;
    return 16'($signed($urandom_range(51472)) - 25736);
  endfunction

  initial begin
    logic [15:0] edges[$];
    int wait_n;
    edges = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
              16'sd12869, -16'sd12869, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    // Directed: extremes, half-pi boundaries and beyond-pi clamping.
    foreach (edges[i]) send_angles(edges[i], edges[(i + 3) % 11], edges[(i + 7) % 11]);
    send_angles(16'h7fff, 16'h7fff, 16'h7fff);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h5555, 16'haaaa, 16'h1234);
    send_angles(16'sd6434, 16'sd6434, 16'sd6434);
    // Random part with a stretch free of gaps and stalls in the middle.
    for (int n = 0; n < 1250; n++) begin
      calm = (n >= 500 && n < 650);
      send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    wait_n = 0;
    while (sb.pending_mats.size() != 0 && wait_n < 20000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_mats.size() != 0) report_mismatch("matrices never arrived");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
